// ----- src/mlpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpf_pkg
// Types and codes shared by the multi-level priority FIFO modules.
// ----------------------------------------------------------------------------
package mlpf_pkg;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DEQUEUED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] ADDR_QUEUE_DEPTH  = 2'd0;
  localparam logic [4:0] QUEUE_DEPTH_RESET = 5'd16;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
    logic        [4:0]  priority_req;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [4:0]  out_priority;
    logic        [1:0]  status;
  } rsp_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] level;
  } op_t;

endpackage

// ----- src/mlpf_ram.sv -----
// ----------------------------------------------------------------------------
// mlpf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mlpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mlpf_level_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlpf_level_ctrl
// Per-level ring pointers and counts, highest-priority search and slot
// store addressing. Decides each item at the edge it is taken.
// ----------------------------------------------------------------------------
module mlpf_level_ctrl #(
  parameter int LEVELS      = 32,
  parameter int LEVEL_DEPTH = 16,
  parameter int DATA_WIDTH  = 32,
  localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  mlpf_pkg::req_item_t   req,
  input  logic [4:0]            depth,
  output mlpf_pkg::op_t         op,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr
);

  localparam int LVL_W = $clog2(LEVELS);
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;

  logic [PTR_W-1:0] head  [LEVELS];
  logic [PTR_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic              is_enq;
  logic              lvl_exists;
  logic              has_room;
  logic              enq_go;
  logic              deq_go;
  logic              any;
  logic [LVL_W-1:0]  enq_lvl;
  logic [LVL_W-1:0]  deq_lvl;
  logic [PTR_W-1:0]  tail_adv;
  logic [PTR_W-1:0]  head_adv;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
                                               input logic [4:0] dep);
    logic [CMP_W-1:0] nxt;
    nxt = CMP_W'(pos) + CMP_W'(1);
    if (nxt >= CMP_W'(dep)) begin
      return '0;
    end
    return PTR_W'(nxt);
  endfunction

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count[i] != '0);
    end
  end

  always_comb begin
    any     = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        any     = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  assign is_enq     = (req.action == mlpf_pkg::ACT_ENQUEUE);
  assign lvl_exists = (int'(req.priority_req) < LEVELS);
  assign enq_lvl    = LVL_W'(req.priority_req);
  assign has_room   = (CMP_W'(count[enq_lvl]) < CMP_W'(depth));
  assign enq_go     = is_enq && lvl_exists && has_room;
  assign deq_go     = !is_enq && any;
  assign tail_adv   = advance(tail[enq_lvl], depth);
  assign head_adv   = advance(head[deq_lvl], depth);

  assign wr_en   = take && enq_go;
  assign wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail[enq_lvl]);
  assign wr_data = DATA_WIDTH'($unsigned(req.value));
  assign rd_en   = take && deq_go;
  assign rd_addr = ADDR_W'(deq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head[deq_lvl]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (take) begin
      if (enq_go) begin
        tail[enq_lvl]  <= tail_adv;
        count[enq_lvl] <= count[enq_lvl] + CNT_W'(1);
      end else if (deq_go) begin
        head[deq_lvl]  <= head_adv;
        count[deq_lvl] <= count[deq_lvl] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (is_enq) begin
        op.status <= enq_go ? mlpf_pkg::ST_ENQUEUED : mlpf_pkg::ST_FULL;
        op.level  <= '0;
      end else if (any) begin
        op.status <= mlpf_pkg::ST_DEQUEUED;
        op.level  <= 5'(deq_lvl);
      end else begin
        op.status <= mlpf_pkg::ST_EMPTY;
        op.level  <= '0;
      end
    end
  end

  a_one_store_op: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("slot store written and read in one cycle");

  a_read_is_dequeue: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> op.status == mlpf_pkg::ST_DEQUEUED)
    else $error("store read without a dequeue result");

  a_no_op_is_reject: assert property (@(posedge clk) disable iff (rst)
    take && !wr_en && !rd_en |=>
      op.status == mlpf_pkg::ST_FULL || op.status == mlpf_pkg::ST_EMPTY)
    else $error("item without store access reported as done");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> nonempty != '0)
    else $error("levels empty right after a store");

endmodule

// ----- src/multi_level_priority_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_level_priority_fifo
// Strict-priority queue with one circular FIFO per priority level.
// ----------------------------------------------------------------------------
// Request channel (req_valid, req_stall, req): action 0 enqueues value at
// level priority_req, action 1 dequeues the head of the lowest-numbered
// non-empty level. Every request gives exactly one item on the response
// channel (rsp_valid, rsp_stall, rsp) with out_value, out_priority and
// status: 0 enqueued, 1 level full (value dropped), 2 dequeued, 3 all empty.
// An item is taken in any cycle in which req_stall is low. The take decides
// it and reads the slot store into a pending stage; the response register
// is loaded from that stage once it is free. Throughput is one item per
// cycle while rsp_stall stays low.
// When the receiver stalls, the response register and one decided item
// behind it are held, and req_stall rises until the response is taken.
// Reset empties every level and sets queue_depth to 16. queue_depth, at
// APB address 0, sets the capacity in use of each level's ring, clamped
// to 1..LEVEL_DEPTH; write it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_level_priority_fifo #(
  parameter int LEVELS      = 32,
  parameter int LEVEL_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mlpf_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mlpf_pkg::rsp_item_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

  logic [4:0]            queue_depth;
  logic [4:0]            depth;
  logic                  take;
  logic                  pend_valid;
  logic                  pend_valid_next;
  logic                  pend_move;
  mlpf_pkg::op_t         op;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           rd_wide;

  assign pready = 1'b1;
  assign prdata = (paddr == mlpf_pkg::ADDR_QUEUE_DEPTH) ? 32'(queue_depth) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_depth <= mlpf_pkg::QUEUE_DEPTH_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == mlpf_pkg::ADDR_QUEUE_DEPTH) begin
      queue_depth <= pwdata[4:0];
    end
  end

  always_comb begin
    if (queue_depth == '0) begin
      depth = 5'd1;
    end else if (int'(queue_depth) > LEVEL_DEPTH) begin
      depth = 5'(LEVEL_DEPTH);
    end else begin
      depth = queue_depth;
    end
  end

  assign pend_move = pend_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pend_valid && !pend_move;
  assign take      = req_valid && !req_stall;

  always_comb begin
    if (take) begin
      pend_valid_next = 1'b1;
    end else if (pend_move) begin
      pend_valid_next = 1'b0;
    end else begin
      pend_valid_next = pend_valid;
    end
  end

  mlpf_level_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .req     (req),
    .depth   (depth),
    .op      (op),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  mlpf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (LEVELS * LEVEL_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_wide = 64'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
      if (pend_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      rsp.out_value    <= (op.status == mlpf_pkg::ST_DEQUEUED) ? rd_wide[31:0] : '0;
      rsp.out_priority <= op.level;
      rsp.status       <= op.status;
    end
  end

endmodule
